// File: hw/rtl/tms_pkg.sv
// Package: shared types, command codes and the note tables of the tone melody sequencer.
package tms_pkg;

    // Command codes carried in func
    localparam logic [1:0] FN_TICK  = 2'd0;
    localparam logic [1:0] FN_CHIME = 2'd1;
    localparam logic [1:0] FN_ALARM = 2'd2;
    localparam logic [1:0] FN_STOP  = 2'd3;

    // Largest forward distance that still counts as "due"
    localparam logic [31:0] C_WAIT_LIMIT = 32'h7FFF_FFFF;

    localparam int unsigned C_FREQ_W = 16;
    localparam int unsigned C_DUR_W  = 16;
    localparam int unsigned C_IDX_W  = 3;

    typedef struct packed {
        logic [C_FREQ_W-1:0] freq;
        logic [C_DUR_W-1:0]  dur;
    } t_note;

    // Status of the serial divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Note tables: table 0 success chime, table 1 alarm; unused slots terminate
    function automatic t_note tms_rom(input logic sel, input logic [C_IDX_W-1:0] idx);
        t_note e;
        e = '{freq: 16'd0, dur: 16'd0};
        if (!sel) begin
            case (idx)
                3'd0:    e = '{freq: 16'd660,  dur: 16'd100};
                3'd1:    e = '{freq: 16'd880,  dur: 16'd100};
                3'd2:    e = '{freq: 16'd1047, dur: 16'd160};
                default: e = '{freq: 16'd0,    dur: 16'd0};
            endcase
        end else begin
            case (idx)
                3'd0:    e = '{freq: 16'd900, dur: 16'd180};
                3'd1:    e = '{freq: 16'd0,   dur: 16'd100};
                3'd2:    e = '{freq: 16'd900, dur: 16'd180};
                3'd3:    e = '{freq: 16'd0,   dur: 16'd100};
                3'd4:    e = '{freq: 16'd700, dur: 16'd260};
                default: e = '{freq: 16'd0,   dur: 16'd0};
            endcase
        end
        return e;
    endfunction

endpackage

// File: hw/rtl/tms_ifs.sv
// Interfaces: command input channel and tone setting output channel.
interface tms_in_if
    import tms_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] now_ms;

    modport source (output valid, output func, output now_ms, input ready);
    modport sink   (input valid, input func, input now_ms, output ready);
endinterface

interface tms_out_if
    import tms_pkg::*;
();
    logic        valid;
    logic        ready;
    logic        tone_on;
    logic [15:0] period_reload;
    logic [15:0] duty_compare;
    logic        playing;

    modport source (output valid, output tone_on, output period_reload,
                    output duty_compare, output playing, input ready);
    modport sink   (input valid, input tone_on, input period_reload,
                    input duty_compare, input playing, output ready);
endinterface

// File: hw/rtl/tms_div.sv
// Serial restoring divider: constant dividend over a 16-bit divisor, one quotient bit a cycle.
module tms_div
    import tms_pkg::*;
#(
    parameter int unsigned DIVIDEND = 1000000
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [C_FREQ_W-1:0]                 i_divisor,
    output t_div_stat                           o_stat,
    output logic [$clog2(DIVIDEND+1)-1:0]       o_quot
);
    localparam int unsigned QW = $clog2(DIVIDEND + 1);
    localparam int unsigned CW = $clog2(QW);
    localparam int unsigned RW = C_FREQ_W + 1;
    localparam logic [QW-1:0] C_DVD = QW'(DIVIDEND);

    logic [CW-1:0]       r_cnt,  n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [RW-1:0]       r_rem,  n_rem;
    logic [QW-1:0]       r_quot, n_quot;
    logic [QW-1:0]       r_dvd,  n_dvd;
    logic [C_FREQ_W-1:0] r_dsr,  n_dsr;

    logic [RW-1:0] w_rem_sh;
    logic          w_fits;

    assign w_rem_sh = {r_rem[RW-2:0], r_dvd[QW-1]};
    assign w_fits   = (w_rem_sh >= {1'b0, r_dsr});

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_quot = r_quot;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quot = '0;
            n_dvd  = C_DVD;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            // one trial subtraction a cycle
            n_rem  = w_fits ? (w_rem_sh - {1'b0, r_dsr}) : w_rem_sh;
            n_quot = {r_quot[QW-2:0], w_fits};
            n_dvd  = {r_dvd[QW-2:0], 1'b0};
            n_cnt  = r_cnt + CW'(1);
            if (r_cnt == CW'(QW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_dvd  <= n_dvd;
        r_dsr  <= n_dsr;
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_quot = r_quot;

endmodule

// File: hw/rtl/tone_melody_sequencer.sv
// Top level: note sequencer that steps a tone table and programs the tone timer.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+--------------------------------------------------
//  i_in    | in  | valid / ready | func[1:0], now_ms[31:0]
//  o_out   | out | valid / ready | tone_on, period_reload[15:0], duty_compare[15:0],
//          |     |               | playing
//
// Every item gives exactly one result item, the tone state after the item.
// Play, stop, idle ticks and silent notes give their result directly; a tick that loads a
// sounding note first waits for the serial divider (QW = bits of TIMER_HZ, 20 at 1 MHz),
// which forms TIMER_HZ / freq one quotient bit a cycle.
// Synchronous active-low reset clears the sequencer state and the divider's control state; no clearing pass is needed.
// A new item is taken while the previous result is being taken; a stalled result
// holds its values and blocks further input.
module tone_melody_sequencer
    import tms_pkg::*;
#(
    parameter int unsigned TIMER_HZ = 1000000
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tms_in_if.sink    i_in,
    tms_out_if.source o_out
);
    localparam int unsigned QW = $clog2(TIMER_HZ + 1);
    localparam int unsigned PW = (QW > 17) ? QW : 17;

    typedef enum logic {S_IDLE, S_DIV} t_state;

    t_state              r_state,  n_state;
    logic                r_active, n_active;
    logic                r_sel,    n_sel;
    logic [C_IDX_W-1:0]  r_idx,    n_idx;
    logic [31:0]         r_due,    n_due;
    logic                r_ton,    n_ton;
    logic [15:0]         r_reload, n_reload;
    logic [15:0]         r_cmp,    n_cmp;
    logic                r_ovalid, n_ovalid;
    logic                n_div_start;

    t_note         w_entry;
    logic [31:0]   w_diff;
    logic          w_wait;
    logic          w_accept;
    t_div_stat     w_div_stat;
    logic [QW-1:0] w_quot;
    logic [PW-1:0] w_per;
    logic [PW-1:0] w_per_m1;
    logic [PW-1:0] w_half;

    tms_div #(
        .DIVIDEND (TIMER_HZ)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (n_div_start),
        .i_divisor (w_entry.freq),
        .o_stat    (w_div_stat),
        .o_quot    (w_quot)
    );

    // Take a new item only with the divider free and the result slot free or draining
    assign i_in.ready = (r_state == S_IDLE) && (!r_ovalid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_entry = tms_rom(r_sel, r_idx);
    // Wraparound compare: a due time ahead of now means wait
    assign w_diff  = i_in.now_ms - r_due;
    assign w_wait  = (r_due != 32'd0) && (w_diff > C_WAIT_LIMIT);

    // Clamp the period to at least 2, then cut reload and compare to 16 bits
    assign w_per    = (w_quot < QW'(2)) ? PW'(2) : PW'(w_quot);
    assign w_per_m1 = w_per - PW'(1);
    assign w_half   = w_per >> 1;

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_sel       = r_sel;
        n_idx       = r_idx;
        n_due       = r_due;
        n_ton       = r_ton;
        n_reload    = r_reload;
        n_cmp       = r_cmp;
        n_ovalid    = r_ovalid;
        n_div_start = 1'b0;

        // drop the result once taken
        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_ovalid = 1'b1;
                    unique case (i_in.func) inside
                        FN_TICK: begin
                            if (r_active && !w_wait) begin
                                if (w_entry.dur == '0) begin
                                    // terminating entry: halt the sequence
                                    n_active = 1'b0;
                                    n_idx    = '0;
                                    n_due    = '0;
                                    n_ton    = 1'b0;
                                    n_cmp    = '0;
                                end else begin
                                    n_due = i_in.now_ms + 32'(w_entry.dur);
                                    n_idx = r_idx + C_IDX_W'(1);
                                    if (w_entry.freq == '0) begin
                                        // rest: silence, keep the last reload
                                        n_ton = 1'b0;
                                        n_cmp = '0;
                                    end else begin
                                        // hold the result until the period is known
                                        n_ovalid    = 1'b0;
                                        n_div_start = 1'b1;
                                        n_state     = S_DIV;
                                    end
                                end
                            end
                        end
                        FN_CHIME, FN_ALARM: begin
                            n_sel    = (i_in.func == FN_ALARM);
                            n_idx    = '0;
                            n_active = 1'b1;
                            n_due    = '0;
                        end
                        default: begin
                            n_active = 1'b0;
                            n_idx    = '0;
                            n_due    = '0;
                            n_ton    = 1'b0;
                            n_cmp    = '0;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_reload = w_per_m1[15:0];
                    n_cmp    = w_half[15:0];
                    n_ton    = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_sel    <= 1'b0;
            r_idx    <= '0;
            r_due    <= '0;
            r_ton    <= 1'b0;
            r_reload <= '0;
            r_cmp    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_sel    <= n_sel;
            r_idx    <= n_idx;
            r_due    <= n_due;
            r_ton    <= n_ton;
            r_reload <= n_reload;
            r_cmp    <= n_cmp;
            r_ovalid <= n_ovalid;
        end
    end

    // State registers double as the output register
    assign o_out.valid         = r_ovalid;
    assign o_out.tone_on       = r_ton;
    assign o_out.period_reload = r_reload;
    assign o_out.duty_compare  = r_cmp;
    assign o_out.playing       = r_active;

    a_silent_when_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (!r_ton && r_cmp == 16'd0))
        else $error("tone left running with no active sequence");

    a_off_clears_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ton |-> (r_cmp == 16'd0))
        else $error("compare value nonzero while tone is off");

    a_done_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_result_not_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (!r_ovalid && w_div_stat.busy != w_div_stat.done))
        else $error("result shown or divider idle while dividing");

endmodule

// File: tb/tone_melody_sequencer_tb.sv
// Testbench: directed and random command streams for the tone melody sequencer.
module tone_melody_sequencer_tb
    import tms_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TONE_HZ     = 1000000;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    // Settle time that covers the slowest item, a tick that runs the serial divider over the bits of the timer rate
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned PHASE_ITEMS   = 335;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] now_ms;
    } t_cmd_item;

    typedef struct {
        logic        tone_on;
        logic [15:0] period_reload;
        logic [15:0] duty_compare;
        logic        playing;
    } t_tone_state;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tms_in_if  in_if ();
    tms_out_if out_if ();

    tone_melody_sequencer #(
        .TIMER_HZ(TONE_HZ)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // Commands waiting for the driver, and tone states waiting for the monitor
    t_cmd_item   pending_cmds[$];
    t_tone_state expected_tones[$];

    // Idle percentages, changed only between phases
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    // Predicted sequencer state
    logic        seq_on;
    logic        seq_alarm;
    logic [2:0]  seq_step;
    logic [31:0] seq_due;
    logic        gen_on;
    logic [15:0] gen_reload;
    logic [15:0] gen_compare;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Note tables: chime has three notes, alarm five steps; everything past the end
    // reads as a terminator of duration zero.
    function automatic t_note note_at(input logic alarm, input logic [2:0] step);
        t_note n;
        n = '{freq: 16'd0, dur: 16'd0};
        case ({alarm, step})
            4'b0_000: n = '{freq: 16'd660,  dur: 16'd100};
            4'b0_001: n = '{freq: 16'd880,  dur: 16'd100};
            4'b0_010: n = '{freq: 16'd1047, dur: 16'd160};
            4'b1_000: n = '{freq: 16'd900,  dur: 16'd180};
            4'b1_001: n = '{freq: 16'd0,    dur: 16'd100};
            4'b1_010: n = '{freq: 16'd900,  dur: 16'd180};
            4'b1_011: n = '{freq: 16'd0,    dur: 16'd100};
            4'b1_100: n = '{freq: 16'd700,  dur: 16'd260};
            default:  n = '{freq: 16'd0,    dur: 16'd0};
        endcase
        return n;
    endfunction

    // Program the tone generator; frequency zero silences it but keeps the reload
    task automatic load_generator(input logic [15:0] freq);
        int unsigned period;
        if (freq == 16'd0) begin
            gen_compare = 16'd0;
            gen_on      = 1'b0;
        end else begin
            period = TONE_HZ / freq;
            if (period < 2) begin
                period = 2;
            end
            gen_reload  = 16'(period - 1);
            gen_compare = 16'(period / 2);
            gen_on      = 1'b1;
        end
    endtask

    task automatic halt_melody();
        seq_on   = 1'b0;
        seq_step = 3'd0;
        seq_due  = 32'd0;
        load_generator(16'd0);
    endtask

    // Advance the predicted state by one command and return the tone state after it
    task automatic predict_tone(input t_cmd_item c, output t_tone_state r);
        t_note n;
        case (c.func) inside
            FN_TICK: begin
                // Skip when idle, or when the due time is still ahead (wrapping compare);
                // a due time of zero is due at once
                if (seq_on && !(seq_due != 32'd0 && (c.now_ms - seq_due) > C_WAIT_LIMIT)) begin
                    n = note_at(seq_alarm, seq_step);
                    if (n.dur == 16'd0) begin
                        halt_melody();
                    end else begin
                        load_generator(n.freq);
                        seq_due  = c.now_ms + 32'(n.dur);
                        seq_step = seq_step + 3'd1;
                    end
                end
            end
            FN_CHIME, FN_ALARM: begin
                // Restart the table; the current tone stays until the next tick
                seq_alarm = (c.func == FN_ALARM);
                seq_step  = 3'd0;
                seq_on    = 1'b1;
                seq_due   = 32'd0;
            end
            default: begin
                halt_melody();
            end
        endcase
        r = '{tone_on: gen_on, period_reload: gen_reload, duty_compare: gen_compare,
              playing: seq_on};
    endtask

    // Driver: record the accepted item, then offer the next one or idle
    always @(posedge i_clk) begin
        t_cmd_item   c;
        t_tone_state r;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                c.func   = in_if.func;
                c.now_ms = in_if.now_ms;
                predict_tone(c, r);
                expected_tones.push_back(r);
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    c = pending_cmds.pop_front();
                    in_if.valid  <= 1'b1;
                    in_if.func   <= c.func;
                    in_if.now_ms <= c.now_ms;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction, then stall or not
    always @(posedge i_clk) begin
        t_tone_state e;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_tones.size() == 0) begin
                    $error("result item arrived with no prediction waiting");
                    fail_count++;
                end else begin
                    e = expected_tones.pop_front();
                    if (out_if.tone_on !== e.tone_on) begin
                        $error("tone_on: expected %0d, actual %0d", e.tone_on, out_if.tone_on);
                        fail_count++;
                    end
                    if (out_if.period_reload !== e.period_reload) begin
                        $error("period_reload: expected %0d, actual %0d",
                               e.period_reload, out_if.period_reload);
                        fail_count++;
                    end
                    if (out_if.duty_compare !== e.duty_compare) begin
                        $error("duty_compare: expected %0d, actual %0d",
                               e.duty_compare, out_if.duty_compare);
                        fail_count++;
                    end
                    if (out_if.playing !== e.playing) begin
                        $error("playing: expected %0d, actual %0d", e.playing, out_if.playing);
                        fail_count++;
                    end
                end
            end
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_cmd(input logic [1:0] func, input logic [31:0] now_ms);
        t_cmd_item c;
        c.func   = func;
        c.now_ms = now_ms;
        pending_cmds.push_back(c);
    endtask

    // Hold the sender until every queued item is sent and every result has come
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || in_if.valid || expected_tones.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Mostly play-then-tick melodies with random start times and steps that land
    // before, on and after the due time; the rest is noise on every field.
    task automatic queue_random_melodies(input int unsigned count);
        int unsigned made;
        int unsigned steps;
        int unsigned pick;
        logic [31:0] t;
        logic        alarm;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                push_cmd(2'($urandom_range(3)), $urandom());
                made++;
            end else begin
                alarm = 1'($urandom_range(1));
                push_cmd(alarm ? FN_ALARM : FN_CHIME, $urandom());
                made++;
                t = $urandom();
                // Sometimes start so that the first due time wraps to exactly zero
                if ($urandom_range(9) == 0) begin
                    t = 32'd0 - (alarm ? 32'd180 : 32'd100);
                end
                steps = $urandom_range(4, 16);
                repeat (steps) begin
                    pick = $urandom_range(99);
                    if (pick < 55) begin
                        t += $urandom_range(90, 300);
                    end else if (pick < 85) begin
                        t += $urandom_range(0, 60);
                    end else if (pick < 90) begin
                        // Land on either side of the half-range wait limit
                        t += 32'h7FFF_FFFF + $urandom_range(0, 2);
                    end
                    if (pick >= 96) begin
                        push_cmd(pick[0] ? FN_STOP : ($urandom_range(1) ? FN_ALARM : FN_CHIME),
                                 t);
                    end else begin
                        push_cmd(FN_TICK, t);
                    end
                    made++;
                end
            end
        end
    endtask

    initial begin
        logic [31:0] d;
        in_if.valid   = 1'b0;
        in_if.func    = FN_TICK;
        in_if.now_ms  = 32'd0;
        out_if.ready  = 1'b0;

        seq_on      = 1'b0;
        seq_alarm   = 1'b0;
        seq_step    = 3'd0;
        seq_due     = 32'd0;
        gen_on      = 1'b0;
        gen_reload  = 16'd0;
        gen_compare = 16'd0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle tick and stop, then a chime whose first due time wraps to zero
        push_cmd(FN_TICK, 32'd0);
        push_cmd(FN_STOP, 32'hFFFF_FFFF);
        push_cmd(FN_CHIME, 32'hFFFF_FFFF);
        push_cmd(FN_TICK, 32'hFFFF_FF9C);
        push_cmd(FN_TICK, 32'd5);      // due at once, next due 105
        push_cmd(FN_TICK, 32'd50);     // still waiting
        push_cmd(FN_TICK, 32'd105);    // exactly due
        push_cmd(FN_TICK, 32'd265);    // terminator silences, reload kept
        push_cmd(FN_TICK, 32'd300);    // no sequence running

        // Alarm with a silent step and both edges of the wait window
        push_cmd(FN_ALARM, 32'd0);
        push_cmd(FN_TICK, 32'd1000);
        push_cmd(FN_TICK, 32'd1180);   // silent step, due 1280
        push_cmd(FN_TICK, 32'd1280 + 32'h7FFF_FFFF);
        d = 32'd1280 + 32'h7FFF_FFFF + 32'd180;
        push_cmd(FN_TICK, d - 32'd1);
        push_cmd(FN_TICK, d + 32'h8000_0000);
        push_cmd(FN_TICK, d);
        push_cmd(FN_TICK, d + 32'd100); // last alarm note sounding
        push_cmd(FN_CHIME, 32'd7);      // restart while the tone sounds
        push_cmd(FN_TICK, 32'h1234_5678);
        push_cmd(FN_STOP, 32'd0);
        push_cmd(FN_ALARM, 32'hFFFF_FFFF);
        push_cmd(FN_TICK, 32'hFFFF_FFFF);
        push_cmd(FN_TICK, 32'd0);
        queue_random_melodies(PHASE_ITEMS);
        wait_drained();

        // Sender idle most of the time
        send_idle_pct  = 73;
        recv_stall_pct = 0;
        queue_random_melodies(PHASE_ITEMS);
        wait_drained();

        // Receiver stalling most of the time
        send_idle_pct  = 0;
        recv_stall_pct = 73;
        queue_random_melodies(PHASE_ITEMS);
        wait_drained();

        // Both sides idle now and then
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        queue_random_melodies(PHASE_ITEMS);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_tones.size() != 0) begin
            $error("%0d predicted results never arrived", expected_tones.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
